[hdl/crcfc_pkg.sv]
// shared types, constants and crc helper for the crc16 frame checker
package crcfc_pkg;

  // covered bytes, then crc low, crc high, tail first, tail second
  localparam int unsigned CrcBytes = 35;
  localparam int unsigned PosW     = $clog2(CrcBytes + 5);

  localparam logic [PosW-1:0] PosCmd    = PosW'(2);
  localparam logic [PosW-1:0] PosCrcLo  = PosW'(CrcBytes);
  localparam logic [PosW-1:0] PosCrcHi  = PosW'(CrcBytes + 1);
  localparam logic [PosW-1:0] PosTail0  = PosW'(CrcBytes + 2);
  localparam logic [PosW-1:0] PosTail1  = PosW'(CrcBytes + 3);
  localparam logic [PosW-1:0] PosIdle   = PosW'(CrcBytes + 4);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef enum logic [1:0] {
    CfgHeaderFirst  = 2'd0,
    CfgHeaderSecond = 2'd1,
    CfgTailFirst    = 2'd2,
    CfgTailSecond   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FailNone   = 2'd0,
    FailHeader = 2'd1,
    FailTail   = 2'd2,
    FailCrc    = 2'd3
  } fail_cause_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } frame_in_t;

  typedef struct packed {
    logic        frame_ok;
    fail_cause_e fail_cause;
    logic [7:0]  command;
    logic [15:0] computed_crc;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] tail_first;
    logic [7:0] tail_second;
  } cfg_t;

  // reflected crc16 update, one byte, unrolled
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hdl/crcfc_frame_core.sv]
// byte position tracking, crc accumulation and marker compares for one frame
module crcfc_frame_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                byte_fire_i,
  input  crcfc_pkg::frame_in_t byte_i,
  input  crcfc_pkg::cfg_t     cfg_i,
  output logic                res_valid_o,
  output crcfc_pkg::frame_res_t res_o
);
  import crcfc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic            header_match_q, header_match_d;
  logic            tail_match_q, tail_match_d;
  logic            crc_match_q, crc_match_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [7:0]      command_q, command_d;

  logic [PosW-1:0] pos;
  logic [7:0]      b;
  logic            active;
  logic [15:0]     crc_base;
  logic            tail_final;

  assign b      = byte_i.rx_byte;
  assign pos    = byte_i.frame_start ? '0 : pos_q;
  assign active = pos < PosIdle;

  // byte 0 restarts the crc and the match flags
  assign crc_base   = (pos == '0) ? CrcInit : crc_q;
  assign tail_final = tail_match_q && (b == cfg_i.tail_second);

  always_comb begin
    pos_d          = pos_q;
    crc_d          = crc_q;
    header_match_d = header_match_q;
    tail_match_d   = tail_match_q;
    crc_match_d    = crc_match_q;
    crc_lo_d       = crc_lo_q;
    command_d      = command_q;
    if (byte_fire_i) begin
      if (!active) begin
        pos_d = PosIdle;
      end else begin
        pos_d = pos + PosW'(1);
        if (pos == '0) begin
          tail_match_d = 1'b1;
          crc_match_d  = 1'b0;
        end
        if (pos < PosCrcLo) begin
          crc_d = crc16_byte(crc_base, b);
        end
        if (pos == '0) begin
          header_match_d = (b == cfg_i.header_first);
        end
        if (pos == PosW'(1)) begin
          header_match_d = header_match_q && (b == cfg_i.header_second);
        end
        if (pos == PosCmd) begin
          command_d = b;
        end
        if (pos == PosCrcLo) begin
          crc_lo_d = b;
        end
        if (pos == PosCrcHi) begin
          crc_match_d = ({b, crc_lo_q} == crc_q);
        end
        if (pos == PosTail0) begin
          tail_match_d = (b == cfg_i.tail_first);
        end
        if (pos == PosTail1) begin
          tail_match_d = tail_final;
        end
      end
    end
  end

  // result on the last byte of the frame
  always_comb begin
    res_valid_o        = byte_fire_i && (pos == PosTail1);
    res_o.command      = command_q;
    res_o.computed_crc = crc_q;
    if (!header_match_q) begin
      res_o.fail_cause = FailHeader;
    end else if (!tail_final) begin
      res_o.fail_cause = FailTail;
    end else if (!crc_match_q) begin
      res_o.fail_cause = FailCrc;
    end else begin
      res_o.fail_cause = FailNone;
    end
    res_o.frame_ok = (res_o.fail_cause == FailNone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      crc_q          <= CrcInit;
      header_match_q <= 1'b1;
      tail_match_q   <= 1'b1;
      crc_match_q    <= 1'b0;
      crc_lo_q       <= '0;
      command_q      <= '0;
    end else begin
      pos_q          <= pos_d;
      crc_q          <= crc_d;
      header_match_q <= header_match_d;
      tail_match_q   <= tail_match_d;
      crc_match_q    <= crc_match_d;
      crc_lo_q       <= crc_lo_d;
      command_q      <= command_d;
    end
  end

endmodule

[hdl/crc16_frame_checker.sv]
// top level of the crc16 frame checker: input stage, config registers, result register
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i   (rx_byte, frame_start)
//   out      output     out_valid_o/out_ready_i out_data_o  (frame_ok, fail_cause, ...)
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one beat per cycle sustained on the input while no result is stalled; the crc byte
// update is combinational xor logic between the input stage and the crc register.
// a result is registered after its last byte has passed from the input stage into the core.
// reset returns the byte position to frame byte 0 and all markers to zero.
// a stalled result holds the input stage; one byte waits there, then in_ready_o drops.
module crc16_frame_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  crcfc_pkg::frame_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output crcfc_pkg::frame_res_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [7:0]            cfg_wdata_i
);
  import crcfc_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       s1_valid_q, s1_valid_d;
  frame_in_t  s1_q;
  logic       out_valid_q, out_valid_d;
  frame_res_t out_q;

  logic       s1_adv;
  logic       in_fire;
  logic       core_fire;
  logic       res_valid;
  frame_res_t res;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign core_fire  = s1_valid_q && s1_adv;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgHeaderFirst:  cfg_d.header_first  = cfg_wdata_i;
        CfgHeaderSecond: cfg_d.header_second = cfg_wdata_i;
        CfgTailFirst:    cfg_d.tail_first    = cfg_wdata_i;
        CfgTailSecond:   cfg_d.tail_second   = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (core_fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  crcfc_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (core_fire),
    .byte_i      (s1_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
    if (core_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ok_matches_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.frame_ok == (out_data_o.fail_cause == FailNone)))
    else $error("frame_ok disagrees with fail_cause");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input stage changed while blocked");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !core_fire)
    else $error("core fired while result register was full");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && $past(!out_valid_q) && out_valid_d) |-> s1_valid_q)
    else $error("result produced without a byte in the input stage");
`endif

endmodule

[tb/tb_top.sv]
// self-checking testbench for crc16_frame_checker: directed frames, then random frame traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crcfc_pkg::*;

  localparam int unsigned FrameLen    = CrcBytes + 4;
  localparam int unsigned RandBeats   = 600;
  localparam int unsigned QuietAfter  = 480;
  localparam int unsigned MinReports  = 20;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned NumRows     = 13;

  localparam cfg_t MarkZero = '{8'h00, 8'h00, 8'h00, 8'h00};
  localparam cfg_t MarkOnes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
  localparam cfg_t MarkSync = '{8'hAA, 8'h55, 8'h0D, 8'h0A};

  // one directed frame: optional marker load, then the first nbytes of the frame
  typedef struct packed {
    logic        set_cfg;
    cfg_t        cfg;
    logic        start;
    logic [5:0]  nbytes;
    logic [7:0]  hdr0, hdr1, cmd, fill, tail0, tail1;
    logic        crc_bad;
    logic        typed;
    fail_cause_e cause;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  frame_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  frame_res_t out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = 2'd0;
  logic [7:0] cfg_wdata = 8'h00;

  // frame tracker state
  cfg_t        markers = '0;
  logic [5:0]  trk_pos = 6'd0;
  logic [15:0] trk_crc = CrcInit;
  logic        trk_hdr_ok = 1'b1;
  logic        trk_tail_ok = 1'b1;
  logic        trk_crc_ok = 1'b0;
  logic [7:0]  trk_crc_lo = 8'h00;
  logic [7:0]  trk_cmd = 8'h00;

  frame_res_t  pending_reports[$];
  int unsigned reports_due = 0;
  int unsigned beats_sent = 0;
  int unsigned err_count = 0;
  logic        typed_ok = 1'b0;
  fail_cause_e typed_cause = FailNone;
  logic        hold_go = 1'b0;
  logic        no_idle = 1'b0;
  logic [7:0]  frame_buf [FrameLen];
  dir_row_t    dir_rows [NumRows];

  crc16_frame_checker u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] a;
    a = acc ^ {8'h00, b};
    repeat (8) a = a[0] ? ((a >> 1) ^ CrcPoly) : (a >> 1);
    return a;
  endfunction

  task automatic track_byte(input frame_in_t beat);
    int unsigned p;
    fail_cause_e c;
    frame_res_t  r;
    p = beat.frame_start ? 0 : int'(trk_pos);
    // past the last byte only a start flag reopens a frame
    if (p >= FrameLen) begin
      trk_pos = 6'(FrameLen);
      return;
    end
    if (p == 0) begin
      trk_crc     = CrcInit;
      trk_hdr_ok  = 1'b1;
      trk_tail_ok = 1'b1;
      trk_crc_ok  = 1'b0;
    end
    if (p < CrcBytes) trk_crc = crc_step(trk_crc, beat.rx_byte);
    if (p == 0) trk_hdr_ok = (beat.rx_byte == markers.header_first);
    if (p == 1) trk_hdr_ok = trk_hdr_ok && (beat.rx_byte == markers.header_second);
    if (p == 2) trk_cmd = beat.rx_byte;
    if (p == CrcBytes) trk_crc_lo = beat.rx_byte;
    if (p == CrcBytes + 1) trk_crc_ok = ({beat.rx_byte, trk_crc_lo} == trk_crc);
    if (p == CrcBytes + 2) trk_tail_ok = (beat.rx_byte == markers.tail_first);
    if (p == CrcBytes + 3) begin
      trk_tail_ok = trk_tail_ok && (beat.rx_byte == markers.tail_second);
      if (!trk_hdr_ok) c = FailHeader;
      else if (!trk_tail_ok) c = FailTail;
      else if (!trk_crc_ok) c = FailCrc;
      else c = FailNone;
      if (typed_ok) c = typed_cause;
      r.frame_ok     = (c == FailNone);
      r.fail_cause   = c;
      r.command      = trk_cmd;
      r.computed_crc = trk_crc;
      pending_reports.push_back(r);
      reports_due++;
    end
    trk_pos = 6'(p + 1);
  endtask

  always @(posedge clk) begin : monitor
    frame_res_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected frame report: %p", out_data);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          if (out_data.frame_ok !== want.frame_ok) begin
            $error("frame_ok: expected %0d, got %0d", want.frame_ok, out_data.frame_ok);
            err_count++;
          end
          if (out_data.fail_cause !== want.fail_cause) begin
            $error("fail_cause: expected %0d, got %0d", want.fail_cause, out_data.fail_cause);
            err_count++;
          end
          if (out_data.command !== want.command) begin
            $error("command: expected %02h, got %02h", want.command, out_data.command);
            err_count++;
          end
          if (out_data.computed_crc !== want.computed_crc) begin
            $error("computed_crc: expected %04h, got %04h", want.computed_crc,
                   out_data.computed_crc);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) track_byte(in_data);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic st);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.rx_byte = b;
    in_data.frame_start = st;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (beats_sent >= QuietAfter) no_idle = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_frame(input int unsigned n, input logic st);
    for (int k = 0; k < n; k++) send_beat(frame_buf[k], (k == 0) ? st : 1'b0);
  endtask

  // append crc (optionally corrupted) and tail to the covered bytes in frame_buf
  task automatic seal_frame(input logic [15:0] flip, input logic [7:0] t0,
                            input logic [7:0] t1);
    logic [15:0] c;
    c = CrcInit;
    for (int k = 0; k < CrcBytes; k++) c = crc_step(c, frame_buf[k]);
    c ^= flip;
    frame_buf[CrcBytes]     = c[7:0];
    frame_buf[CrcBytes + 1] = c[15:8];
    frame_buf[CrcBytes + 2] = t0;
    frame_buf[CrcBytes + 3] = t1;
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_markers(input cfg_t m);
    cfg_idx_e   idx;
    logic [7:0] v;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CfgHeaderFirst:  v = m.header_first;
        CfgHeaderSecond: v = m.header_second;
        CfgTailFirst:    v = m.tail_first;
        default:         v = m.tail_second;
      endcase
      cfg_we    = 1'b1;
      cfg_idx   = idx;
      cfg_wdata = v;
      @(negedge clk);
    end
    cfg_we  = 1'b0;
    markers = m;
  endtask

  initial begin : sink
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_go) begin
        // long back-pressure so the input side fills up and stalls
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_go   = 1'b0;
        out_ready = 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready = 1'b1;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stim
    dir_row_t    row;
    cfg_t        mk;
    int unsigned kind, n, ph;
    logic [15:0] mask;
    logic [7:0]  h0, h1, t0, t1;

    // first frame after reset without a start flag, then stray bytes after it
    dir_rows[0]  = '{1'b0, MarkZero, 1'b0, 6'd39, 8'h00, 8'h00, 8'h01, 8'h00,
                     8'h00, 8'h00, 1'b0, 1'b1, FailNone};
    dir_rows[1]  = '{1'b0, MarkZero, 1'b0, 6'd4, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 1'b0, 1'b0, FailNone};
    dir_rows[2]  = '{1'b1, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h55, 8'h03, 8'h5A,
                     8'h0D, 8'h0A, 1'b0, 1'b1, FailNone};
    dir_rows[3]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAB, 8'h55, 8'h04, 8'h5A,
                     8'h0D, 8'h0A, 1'b0, 1'b1, FailHeader};
    // header wins over tail and crc
    dir_rows[4]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h54, 8'h05, 8'hA5,
                     8'h0C, 8'h0B, 1'b1, 1'b1, FailHeader};
    dir_rows[5]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h55, 8'h06, 8'hA5,
                     8'h0D, 8'h0B, 1'b1, 1'b1, FailTail};
    dir_rows[6]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h55, 8'h07, 8'h3C,
                     8'h0C, 8'h0A, 1'b0, 1'b1, FailTail};
    dir_rows[7]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h55, 8'h08, 8'h3C,
                     8'h0D, 8'h0A, 1'b1, 1'b1, FailCrc};
    // partial frame, dropped by the restart that follows
    dir_rows[8]  = '{1'b0, MarkSync, 1'b1, 6'd20, 8'h00, 8'h00, 8'h09, 8'hC3,
                     8'h0D, 8'h0A, 1'b0, 1'b0, FailNone};
    dir_rows[9]  = '{1'b0, MarkSync, 1'b1, 6'd39, 8'hAA, 8'h55, 8'hFF, 8'hC3,
                     8'h0D, 8'h0A, 1'b0, 1'b1, FailNone};
    dir_rows[10] = '{1'b1, MarkOnes, 1'b1, 6'd39, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'hFF, 8'hFF, 1'b0, 1'b1, FailNone};
    dir_rows[11] = '{1'b1, MarkZero, 1'b1, 6'd39, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h00, 1'b0, 1'b1, FailNone};
    dir_rows[12] = '{1'b0, MarkZero, 1'b1, 6'd39, 8'h00, 8'h00, 8'h80, 8'h7F,
                     8'h00, 8'h00, 1'b1, 1'b1, FailCrc};

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NumRows; i++) begin
      row = dir_rows[i];
      if (row.set_cfg) begin
        wait_drained();
        load_markers(row.cfg);
      end
      for (int k = 3; k < CrcBytes; k++) frame_buf[k] = row.fill ^ 8'(k);
      frame_buf[0] = row.hdr0;
      frame_buf[1] = row.hdr1;
      frame_buf[2] = row.cmd;
      seal_frame(row.crc_bad ? 16'h0001 : 16'h0000, row.tail0, row.tail1);
      typed_ok    = row.typed;
      typed_cause = row.cause;
      send_frame(row.nbytes, row.start);
    end
    wait_drained();
    typed_ok   = 1'b0;
    beats_sent = 0;
    no_idle    = 1'b0;

    ph = 0;
    while (beats_sent < RandBeats || reports_due < MinReports) begin
      wait_drained();
      case (ph % 4)
        1:       mk = MarkOnes;
        2:       mk = MarkZero;
        default: mk = cfg_t'($urandom);
      endcase
      load_markers(mk);
      if (ph == 1) begin
        @(posedge clk);
        hold_go = 1'b1;
        @(negedge clk);
      end
      repeat (10) begin
        kind = $urandom_range(0, 19);
        if (kind <= 2) begin
          // truncated frame, stray bytes, or noise with random start flags
          n = $urandom_range(1, (kind == 0) ? FrameLen - 1 : 8);
          for (int k = 0; k < n; k++)
            send_beat(8'($urandom),
                      (kind == 2) ? ($urandom_range(0, 3) == 0) : (kind == 0 && k == 0));
        end else begin
          h0 = mk.header_first;
          h1 = mk.header_second;
          t0 = mk.tail_first;
          t1 = mk.tail_second;
          if ($urandom_range(0, 11) == 0) h0 ^= 8'($urandom_range(1, 255));
          if ($urandom_range(0, 11) == 0) h1 ^= 8'($urandom_range(1, 255));
          if ($urandom_range(0, 11) == 0) t0 ^= 8'($urandom_range(1, 255));
          if ($urandom_range(0, 11) == 0) t1 ^= 8'($urandom_range(1, 255));
          mask = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
          for (int k = 0; k < CrcBytes; k++) frame_buf[k] = 8'($urandom);
          frame_buf[0] = h0;
          frame_buf[1] = h1;
          seal_frame(mask, t0, t1);
          send_frame(FrameLen, $urandom_range(0, 9) != 0);
        end
      end
      ph++;
    end

    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
